// File: rtl/core/gni_pkg.sv
// Shared constants for the grid neighbor index block.
// No dependencies; imported by the top level and the neighbor stage.
`default_nettype none

package gni_pkg;

    localparam int unsigned CFG_W     = 11;
    localparam int unsigned CFG_IDX_W = 2;
    localparam int unsigned NBR_CNT   = 6;

    localparam logic [CFG_W-1:0] DIM_RESET = 11'd1024;

    // register indexes on the configuration port
    localparam logic [CFG_IDX_W-1:0] REG_DIM_X = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_DIM_Y = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_DIM_Z = 2'd2;

    // presence mask bit positions
    localparam int unsigned NB_XM = 0;
    localparam int unsigned NB_XP = 1;
    localparam int unsigned NB_YM = 2;
    localparam int unsigned NB_YP = 3;
    localparam int unsigned NB_ZM = 4;
    localparam int unsigned NB_ZP = 5;

endpackage

`default_nettype wire

// File: rtl/core/gni_div.sv
// Pipelined restoring divider, one quotient bit per register stage.
// Standalone; carries a side payload alongside each transaction.
`default_nettype none

module gni_div #(
    parameter int unsigned NUM_W  = 30,
    parameter int unsigned REM_W  = 10,
    parameter int unsigned SIDE_W = 1
) (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              in_valid,
    output logic                   in_ready,
    input  wire logic [NUM_W-1:0]  in_num,
    input  wire logic [SIDE_W-1:0] in_side,
    input  wire logic [REM_W:0]    den,
    output logic                   out_valid,
    input  wire logic              out_ready,
    output logic [NUM_W-1:0]       out_quo,
    output logic [REM_W-1:0]       out_rem,
    output logic [SIDE_W-1:0]      out_side
);

    // qn holds the unconsumed dividend bits on top and the quotient bits below
    logic              v_reg    [NUM_W];
    logic [NUM_W-1:0]  qn_reg   [NUM_W];
    logic [REM_W-1:0]  rem_reg  [NUM_W];
    logic [SIDE_W-1:0] side_reg [NUM_W];
    logic              adv;

    assign adv      = !v_reg[NUM_W-1] || out_ready;
    assign in_ready = adv;

    for (genvar k = 0; k < NUM_W; k++) begin : g_step
        logic              v_prev;
        logic [NUM_W-1:0]  qn_prev;
        logic [REM_W-1:0]  rem_prev;
        logic [SIDE_W-1:0] side_prev;
        logic [REM_W:0]    trial;
        logic [REM_W:0]    diff;
        logic              take;
        logic [REM_W-1:0]  rem_next;
        logic [NUM_W-1:0]  qn_next;

        if (k == 0) begin : g_first
            assign v_prev    = in_valid;
            assign qn_prev   = in_num;
            assign rem_prev  = '0;
            assign side_prev = in_side;
        end else begin : g_rest
            assign v_prev    = v_reg[k-1];
            assign qn_prev   = qn_reg[k-1];
            assign rem_prev  = rem_reg[k-1];
            assign side_prev = side_reg[k-1];
        end

        assign trial    = {rem_prev, qn_prev[NUM_W-1]};
        assign diff     = trial - den;
        assign take     = (trial >= den);
        assign rem_next = take ? diff[REM_W-1:0] : trial[REM_W-1:0];
        assign qn_next  = {qn_prev[NUM_W-2:0], take};

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                v_reg[k] <= 1'b0;
            end else if (adv) begin
                v_reg[k] <= v_prev;
            end
        end

        always_ff @(posedge aclk) begin
            if (adv) begin
                qn_reg[k]   <= qn_next;
                rem_reg[k]  <= rem_next;
                side_reg[k] <= side_prev;
            end
        end
    end

    assign out_valid = v_reg[NUM_W-1];
    assign out_quo   = qn_reg[NUM_W-1];
    assign out_rem   = rem_reg[NUM_W-1];
    assign out_side  = side_reg[NUM_W-1];

endmodule

`default_nettype wire

// File: rtl/core/gni_nbr.sv
// Neighbor index stage: linear base index, six neighbor indices and mask.
// Three register stages, the last one is the result register. Uses gni_pkg.
`default_nettype none

module gni_nbr #(
    parameter int unsigned AXIS_BITS = 10
) (
    input  wire logic                     aclk,
    input  wire logic                     aresetn,
    input  wire logic                     in_valid,
    output logic                          in_ready,
    input  wire logic [AXIS_BITS-1:0]     in_x,
    input  wire logic [AXIS_BITS-1:0]     in_y,
    input  wire logic [AXIS_BITS-1:0]     in_z,
    input  wire logic [AXIS_BITS:0]       dx,
    input  wire logic [AXIS_BITS:0]       dy,
    input  wire logic [AXIS_BITS:0]       dz,
    input  wire logic [2*AXIS_BITS:0]     dxy,
    output logic                          out_valid,
    input  wire logic                     out_ready,
    output logic [AXIS_BITS-1:0]          out_x,
    output logic [AXIS_BITS-1:0]          out_y,
    output logic [AXIS_BITS-1:0]          out_z,
    output logic [3*AXIS_BITS-1:0]        out_xm,
    output logic [3*AXIS_BITS-1:0]        out_xp,
    output logic [3*AXIS_BITS-1:0]        out_ym,
    output logic [3*AXIS_BITS-1:0]        out_yp,
    output logic [3*AXIS_BITS-1:0]        out_zm,
    output logic [3*AXIS_BITS-1:0]        out_zp,
    output logic [gni_pkg::NBR_CNT-1:0]   out_mask
);
    import gni_pkg::*;

    localparam int unsigned A  = AXIS_BITS;
    localparam int unsigned IW = 3 * AXIS_BITS;

    logic [2:0] v_reg;
    logic       adv;

    // stage 1: products and edge flags
    logic [2*A:0]       yd_full;
    logic [3*A+1:0]     zd_full;
    logic [A:0]         x_inc;
    logic [A:0]         y_inc;
    logic [A:0]         z_inc;
    logic [NBR_CNT-1:0] ok_next;
    logic [2*A:0]       yd_reg;
    logic [IW-1:0]      zd_reg;
    logic [NBR_CNT-1:0] ok1_reg;
    logic [A-1:0]       x1_reg;
    logic [A-1:0]       y1_reg;
    logic [A-1:0]       z1_reg;

    // stage 2: base index
    logic [IW-1:0]      base_next;
    logic [IW-1:0]      base_reg;
    logic [NBR_CNT-1:0] ok2_reg;
    logic [A-1:0]       x2_reg;
    logic [A-1:0]       y2_reg;
    logic [A-1:0]       z2_reg;

    // stage 3: result register
    logic [IW-1:0]      dx_ext;
    logic [IW-1:0]      dxy_ext;
    logic [IW-1:0]      xm_next;
    logic [IW-1:0]      xp_next;
    logic [IW-1:0]      ym_next;
    logic [IW-1:0]      yp_next;
    logic [IW-1:0]      zm_next;
    logic [IW-1:0]      zp_next;
    logic [IW-1:0]      xm_reg;
    logic [IW-1:0]      xp_reg;
    logic [IW-1:0]      ym_reg;
    logic [IW-1:0]      yp_reg;
    logic [IW-1:0]      zm_reg;
    logic [IW-1:0]      zp_reg;
    logic [NBR_CNT-1:0] mask_reg;
    logic [A-1:0]       x3_reg;
    logic [A-1:0]       y3_reg;
    logic [A-1:0]       z3_reg;

    assign adv      = !v_reg[2] || out_ready;
    assign in_ready = adv;

    assign yd_full = (2*A+1)'(in_y) * (2*A+1)'(dx);
    assign zd_full = (3*A+2)'(in_z) * (3*A+2)'(dxy);
    assign x_inc   = {1'b0, in_x} + 1'b1;
    assign y_inc   = {1'b0, in_y} + 1'b1;
    assign z_inc   = {1'b0, in_z} + 1'b1;

    always_comb begin
        ok_next        = '0;
        ok_next[NB_XM] = (in_x != '0);
        ok_next[NB_XP] = (x_inc < dx);
        ok_next[NB_YM] = (in_y != '0);
        ok_next[NB_YP] = (y_inc < dy);
        ok_next[NB_ZM] = (in_z != '0);
        ok_next[NB_ZP] = (z_inc < dz);
    end

    assign base_next = {{(IW-A){1'b0}}, x1_reg}
                     + {{(IW-2*A-1){1'b0}}, yd_reg}
                     + zd_reg;

    assign dx_ext  = {{(IW-A-1){1'b0}}, dx};
    assign dxy_ext = {{(IW-2*A-1){1'b0}}, dxy};

    assign xm_next = ok2_reg[NB_XM] ? base_reg - 1'b1    : '0;
    assign xp_next = ok2_reg[NB_XP] ? base_reg + 1'b1    : '0;
    assign ym_next = ok2_reg[NB_YM] ? base_reg - dx_ext  : '0;
    assign yp_next = ok2_reg[NB_YP] ? base_reg + dx_ext  : '0;
    assign zm_next = ok2_reg[NB_ZM] ? base_reg - dxy_ext : '0;
    assign zp_next = ok2_reg[NB_ZP] ? base_reg + dxy_ext : '0;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v_reg <= '0;
        end else if (adv) begin
            v_reg <= {v_reg[1:0], in_valid};
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            yd_reg   <= yd_full;
            zd_reg   <= zd_full[IW-1:0];
            ok1_reg  <= ok_next;
            x1_reg   <= in_x;
            y1_reg   <= in_y;
            z1_reg   <= in_z;

            base_reg <= base_next;
            ok2_reg  <= ok1_reg;
            x2_reg   <= x1_reg;
            y2_reg   <= y1_reg;
            z2_reg   <= z1_reg;

            xm_reg   <= xm_next;
            xp_reg   <= xp_next;
            ym_reg   <= ym_next;
            yp_reg   <= yp_next;
            zm_reg   <= zm_next;
            zp_reg   <= zp_next;
            mask_reg <= ok2_reg;
            x3_reg   <= x2_reg;
            y3_reg   <= y2_reg;
            z3_reg   <= z2_reg;
        end
    end

    assign out_valid = v_reg[2];
    assign out_x     = x3_reg;
    assign out_y     = y3_reg;
    assign out_z     = z3_reg;
    assign out_xm    = xm_reg;
    assign out_xp    = xp_reg;
    assign out_ym    = ym_reg;
    assign out_yp    = yp_reg;
    assign out_zm    = zm_reg;
    assign out_zp    = zp_reg;
    assign out_mask  = mask_reg;

endmodule

`default_nettype wire

// File: rtl/core/grid_neighbor_index_top.sv
// Grid neighbor index: node index -> x/y/z location and six face neighbors.
// Three bit-serial divider pipelines of 3*AXIS_BITS stages each, then three
// neighbor stages. Throughput one transaction per cycle; a full pipeline
// stalls as a whole. Synchronous active-low reset sets all dimensions to 1024,
// empties the pipe. Uses gni_pkg, gni_div and gni_nbr.
`default_nettype none

module grid_neighbor_index_top #(
    parameter int unsigned AXIS_BITS = 10
) (
    input  wire logic                         aclk,
    input  wire logic                         aresetn,

    input  wire logic                         cfg_wr_en,
    input  wire logic [gni_pkg::CFG_IDX_W-1:0] cfg_index,
    input  wire logic [gni_pkg::CFG_W-1:0]    cfg_data,

    input  wire logic                         s_valid,
    output logic                              s_ready,
    input  wire logic [3*AXIS_BITS-1:0]       s_node_index,

    output logic                              m_valid,
    input  wire logic                         m_ready,
    output logic [AXIS_BITS-1:0]              m_loc_x,
    output logic [AXIS_BITS-1:0]              m_loc_y,
    output logic [AXIS_BITS-1:0]              m_loc_z,
    output logic [3*AXIS_BITS-1:0]            m_nbr_xm,
    output logic [3*AXIS_BITS-1:0]            m_nbr_xp,
    output logic [3*AXIS_BITS-1:0]            m_nbr_ym,
    output logic [3*AXIS_BITS-1:0]            m_nbr_yp,
    output logic [3*AXIS_BITS-1:0]            m_nbr_zm,
    output logic [3*AXIS_BITS-1:0]            m_nbr_zp,
    output logic [gni_pkg::NBR_CNT-1:0]       m_present_mask
);
    import gni_pkg::*;

    localparam int unsigned A  = AXIS_BITS;
    localparam int unsigned IW = 3 * AXIS_BITS;
    localparam int unsigned CW = (A + 1 > CFG_W) ? A + 1 : CFG_W;

    logic [CFG_W-1:0] dim_x_reg;
    logic [CFG_W-1:0] dim_y_reg;
    logic [CFG_W-1:0] dim_z_reg;
    logic [A:0]       dx;
    logic [A:0]       dy;
    logic [A:0]       dz;
    logic [2*A+1:0]   dxy_full;
    logic [2*A:0]     dxy_reg;

    logic          d1_valid;
    logic          d1_ready;
    logic [IW-1:0] d1_quo;
    logic [A-1:0]  d1_rem;
    logic          d2_valid;
    logic          d2_ready;
    logic [IW-1:0] d2_quo;
    logic [A-1:0]  d2_rem;
    logic [A-1:0]  d2_side;
    logic          d3_valid;
    logic          d3_ready;
    logic [A-1:0]  d3_rem;
    logic [2*A-1:0] d3_side;

    // zero acts as one, anything above 2^A acts as 2^A
    function automatic logic [A:0] eff_dim(input logic [CFG_W-1:0] raw);
        logic [CW-1:0] ext;
        logic [CW-1:0] lim;
        logic [CW-1:0] res;
        ext = {{(CW-CFG_W){1'b0}}, raw};
        lim = {{(CW-A-1){1'b0}}, 1'b1, {A{1'b0}}};
        if (ext == '0) begin
            res = {{(CW-1){1'b0}}, 1'b1};
        end else if (ext > lim) begin
            res = lim;
        end else begin
            res = ext;
        end
        return res[A:0];
    endfunction

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            dim_x_reg <= DIM_RESET;
            dim_y_reg <= DIM_RESET;
            dim_z_reg <= DIM_RESET;
        end else if (cfg_wr_en) begin
            case (cfg_index)
                REG_DIM_X: dim_x_reg <= cfg_data;
                REG_DIM_Y: dim_y_reg <= cfg_data;
                REG_DIM_Z: dim_z_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    assign dx       = eff_dim(dim_x_reg);
    assign dy       = eff_dim(dim_y_reg);
    assign dz       = eff_dim(dim_z_reg);
    assign dxy_full = (2*A+2)'(dx) * (2*A+2)'(dy);

    // plane stride, settles long before any transaction reaches the neighbor stage
    always_ff @(posedge aclk) begin
        dxy_reg <= dxy_full[2*A:0];
    end

    // x = idx mod dx, q = idx div dx
    gni_div #(
        .NUM_W  (IW),
        .REM_W  (A),
        .SIDE_W (1)
    ) u_div_x (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (s_valid),
        .in_ready  (s_ready),
        .in_num    (s_node_index),
        .in_side   (1'b0),
        .den       (dx),
        .out_valid (d1_valid),
        .out_ready (d1_ready),
        .out_quo   (d1_quo),
        .out_rem   (d1_rem),
        .out_side  ()
    );

    // y = q mod dy
    gni_div #(
        .NUM_W  (IW),
        .REM_W  (A),
        .SIDE_W (A)
    ) u_div_y (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (d1_valid),
        .in_ready  (d1_ready),
        .in_num    (d1_quo),
        .in_side   (d1_rem),
        .den       (dy),
        .out_valid (d2_valid),
        .out_ready (d2_ready),
        .out_quo   (d2_quo),
        .out_rem   (d2_rem),
        .out_side  (d2_side)
    );

    // z wraps modulo dz
    gni_div #(
        .NUM_W  (IW),
        .REM_W  (A),
        .SIDE_W (2*A)
    ) u_div_z (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (d2_valid),
        .in_ready  (d2_ready),
        .in_num    (d2_quo),
        .in_side   ({d2_side, d2_rem}),
        .den       (dz),
        .out_valid (d3_valid),
        .out_ready (d3_ready),
        .out_quo   (),
        .out_rem   (d3_rem),
        .out_side  (d3_side)
    );

    gni_nbr #(
        .AXIS_BITS (A)
    ) u_nbr (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (d3_valid),
        .in_ready  (d3_ready),
        .in_x      (d3_side[2*A-1:A]),
        .in_y      (d3_side[A-1:0]),
        .in_z      (d3_rem),
        .dx        (dx),
        .dy        (dy),
        .dz        (dz),
        .dxy       (dxy_reg),
        .out_valid (m_valid),
        .out_ready (m_ready),
        .out_x     (m_loc_x),
        .out_y     (m_loc_y),
        .out_z     (m_loc_z),
        .out_xm    (m_nbr_xm),
        .out_xp    (m_nbr_xp),
        .out_ym    (m_nbr_ym),
        .out_yp    (m_nbr_yp),
        .out_zm    (m_nbr_zm),
        .out_zp    (m_nbr_zp),
        .out_mask  (m_present_mask)
    );

endmodule

`default_nettype wire

// File: dv/grid_neighbor_index_top_tb.sv
// Self-checking testbench for grid_neighbor_index_top: node index in, location and six neighbors out.
// Depends on gni_pkg and the RTL under rtl/core. It uses random source idles and sink stalls,
// and it holds the sink off for one long stretch so that the pipeline backs up.
`default_nettype none

module grid_neighbor_index_top_tb;
    import gni_pkg::*;

    localparam int unsigned AXIS_BITS       = 10;
    localparam int unsigned IDX_W           = 3 * AXIS_BITS;
    localparam int unsigned AXIS_LIMIT      = 1 << AXIS_BITS;
    localparam int unsigned LATENCY         = 9 * AXIS_BITS + 3;
    localparam int unsigned CYCLE_LIMIT     = 200000;
    localparam int unsigned MAX_REPORTS     = 10;
    localparam int unsigned PHASES          = 12;
    localparam int unsigned ITEMS_PER_PHASE = 160;
    localparam int unsigned HOLD_CYCLES     = 400;

    // no register decodes at this index; writes to it must be dropped
    localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 2'd3;

    typedef struct packed {
        logic [AXIS_BITS-1:0]             loc_x;
        logic [AXIS_BITS-1:0]             loc_y;
        logic [AXIS_BITS-1:0]             loc_z;
        logic [NBR_CNT-1:0][IDX_W-1:0]    nbr;
        logic [NBR_CNT-1:0]               present;
    } node_result_t;

    class node_scoreboard;
        logic [CFG_W-1:0] dim_reg [3];
        node_result_t     pending_nodes [$];
        int unsigned      fail_count;

        function new();
            dim_reg = '{DIM_RESET, DIM_RESET, DIM_RESET};
            fail_count = 0;
        endfunction

        function void set_dim(int unsigned axis, logic [CFG_W-1:0] value);
            dim_reg[axis] = value;
        endfunction

        // zero acts as one, anything past the axis range saturates
        function longint unsigned axis_size(int unsigned axis);
            longint unsigned d;
            d = dim_reg[axis];
            if (d == 0) begin
                d = 1;
            end else if (d > AXIS_LIMIT) begin
                d = AXIS_LIMIT;
            end
            return d;
        endfunction

        function logic [IDX_W-1:0] flat_index(input longint unsigned x, y, z, dx, dy);
            return IDX_W'(x + y * dx + z * dx * dy);
        endfunction

        function node_result_t locate_node(logic [IDX_W-1:0] node);
            longint unsigned dx, dy, dz, x, y, z, q;
            node_result_t r;
            dx = axis_size(0);
            dy = axis_size(1);
            dz = axis_size(2);
            x = node % dx;
            q = node / dx;
            y = q % dy;
            z = (q / dy) % dz;  // z wraps for indices past the grid
            r = '0;
            r.loc_x = AXIS_BITS'(x);
            r.loc_y = AXIS_BITS'(y);
            r.loc_z = AXIS_BITS'(z);
            r.present[NB_XM] = (x > 0);
            r.present[NB_XP] = (x + 1 < dx);
            r.present[NB_YM] = (y > 0);
            r.present[NB_YP] = (y + 1 < dy);
            r.present[NB_ZM] = (z > 0);
            r.present[NB_ZP] = (z + 1 < dz);
            if (r.present[NB_XM]) r.nbr[NB_XM] = flat_index(x - 1, y, z, dx, dy);
            if (r.present[NB_XP]) r.nbr[NB_XP] = flat_index(x + 1, y, z, dx, dy);
            if (r.present[NB_YM]) r.nbr[NB_YM] = flat_index(x, y - 1, z, dx, dy);
            if (r.present[NB_YP]) r.nbr[NB_YP] = flat_index(x, y + 1, z, dx, dy);
            if (r.present[NB_ZM]) r.nbr[NB_ZM] = flat_index(x, y, z - 1, dx, dy);
            if (r.present[NB_ZP]) r.nbr[NB_ZP] = flat_index(x, y, z + 1, dx, dy);
            return r;
        endfunction

        function void note_input(logic [IDX_W-1:0] node);
            pending_nodes.push_back(locate_node(node));
        endfunction

        function void flag(string msg);
            fail_count++;
            if (fail_count <= MAX_REPORTS) $display("%s", msg);
        endfunction

        function void compare_field(string name, logic [IDX_W-1:0] want, logic [IDX_W-1:0] got);
            if (got !== want)
                flag($sformatf("mismatch on %s: expected 0x%0h, got 0x%0h", name, want, got));
        endfunction

        function void check_result(node_result_t got);
            node_result_t want;
            if (pending_nodes.size() == 0) begin
                flag("result transaction with nothing outstanding");
                return;
            end
            want = pending_nodes.pop_front();
            compare_field("loc_x", want.loc_x, got.loc_x);
            compare_field("loc_y", want.loc_y, got.loc_y);
            compare_field("loc_z", want.loc_z, got.loc_z);
            compare_field("nbr_xm", want.nbr[NB_XM], got.nbr[NB_XM]);
            compare_field("nbr_xp", want.nbr[NB_XP], got.nbr[NB_XP]);
            compare_field("nbr_ym", want.nbr[NB_YM], got.nbr[NB_YM]);
            compare_field("nbr_yp", want.nbr[NB_YP], got.nbr[NB_YP]);
            compare_field("nbr_zm", want.nbr[NB_ZM], got.nbr[NB_ZM]);
            compare_field("nbr_zp", want.nbr[NB_ZP], got.nbr[NB_ZP]);
            compare_field("present_mask", want.present, got.present);
        endfunction
    endclass

    logic                    aclk;
    logic                    aresetn;
    logic                    cfg_wr_en;
    logic [CFG_IDX_W-1:0]    cfg_index;
    logic [CFG_W-1:0]        cfg_data;
    logic                    s_valid;
    logic                    s_ready;
    logic [IDX_W-1:0]        s_node_index;
    logic                    m_valid;
    logic                    m_ready;
    logic [AXIS_BITS-1:0]    m_loc_x;
    logic [AXIS_BITS-1:0]    m_loc_y;
    logic [AXIS_BITS-1:0]    m_loc_z;
    logic [IDX_W-1:0]        m_nbr_xm;
    logic [IDX_W-1:0]        m_nbr_xp;
    logic [IDX_W-1:0]        m_nbr_ym;
    logic [IDX_W-1:0]        m_nbr_yp;
    logic [IDX_W-1:0]        m_nbr_zm;
    logic [IDX_W-1:0]        m_nbr_zp;
    logic [NBR_CNT-1:0]      m_present_mask;

    node_scoreboard sb;
    int unsigned    send_idle_pct  = 0;
    int unsigned    recv_stall_pct = 0;
    int unsigned    hold_left      = 0;
    int unsigned    cycle_count    = 0;

    grid_neighbor_index_top #(
        .AXIS_BITS(AXIS_BITS)
    ) DUT (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_node_index  (s_node_index),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_loc_x       (m_loc_x),
        .m_loc_y       (m_loc_y),
        .m_loc_z       (m_loc_z),
        .m_nbr_xm      (m_nbr_xm),
        .m_nbr_xp      (m_nbr_xp),
        .m_nbr_ym      (m_nbr_ym),
        .m_nbr_yp      (m_nbr_yp),
        .m_nbr_zm      (m_nbr_zm),
        .m_nbr_zp      (m_nbr_zp),
        .m_present_mask(m_present_mask)
    );

    initial begin
        aclk = 1'b0;
        forever #10 aclk = ~aclk;
    end

    initial begin
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge aclk);
            cycle_count++;
        end
        $display("Regression FAIL");
        $finish;
    end

    // sink: check each accepted result, then pick ready for the next cycle
    initial begin
        node_result_t got;
        m_ready <= 1'b0;
        forever begin
            @(posedge aclk);
            if (aresetn && m_valid && m_ready) begin
                got.loc_x          = m_loc_x;
                got.loc_y          = m_loc_y;
                got.loc_z          = m_loc_z;
                got.nbr[NB_XM]     = m_nbr_xm;
                got.nbr[NB_XP]     = m_nbr_xp;
                got.nbr[NB_YM]     = m_nbr_ym;
                got.nbr[NB_YP]     = m_nbr_yp;
                got.nbr[NB_ZM]     = m_nbr_zm;
                got.nbr[NB_ZP]     = m_nbr_zp;
                got.present        = m_present_mask;
                sb.check_result(got);
            end
            if (hold_left != 0) begin
                hold_left--;
                m_ready <= 1'b0;
            end else begin
                m_ready <= ($urandom_range(99) >= recv_stall_pct);
            end
        end
    end

    // every write also hits the undecoded index, which must leave the grid alone
    task automatic program_grid(input logic [CFG_W-1:0] dx, dy, dz);
        cfg_wr_en <= 1'b1;
        cfg_index <= REG_DIM_X;
        cfg_data  <= dx;
        @(posedge aclk);
        cfg_index <= REG_DIM_Y;
        cfg_data  <= dy;
        @(posedge aclk);
        cfg_index <= REG_DIM_Z;
        cfg_data  <= dz;
        @(posedge aclk);
        cfg_index <= REG_UNUSED;
        cfg_data  <= CFG_W'($urandom);
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        sb.set_dim(0, dx);
        sb.set_dim(1, dy);
        sb.set_dim(2, dz);
    endtask

    task automatic send_node(input logic [IDX_W-1:0] node);
        while ($urandom_range(99) < send_idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid      <= 1'b1;
        s_node_index <= node;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        sb.note_input(node);
    endtask

    task automatic drain_pipe();
        s_valid <= 1'b0;
        while (sb.pending_nodes.size() != 0) @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    function automatic longint unsigned pick_coord(longint unsigned n);
        case ($urandom_range(2))
            0:       return 0;
            1:       return n - 1;
            default: return $urandom_range(32'(n - 1));
        endcase
    endfunction

    // mostly in-grid nodes, biased toward faces; some raw indices and some past the grid
    function automatic logic [IDX_W-1:0] pick_node();
        longint unsigned dx, dy, dz, x, y, z;
        int unsigned kind;
        dx = sb.axis_size(0);
        dy = sb.axis_size(1);
        dz = sb.axis_size(2);
        kind = $urandom_range(9);
        if (kind < 2) return IDX_W'($urandom);
        if (kind < 6) return IDX_W'($urandom_range(32'(dx * dy * dz - 1)));
        x = pick_coord(dx);
        y = pick_coord(dy);
        z = pick_coord(dz);
        if (kind == 9) z = z + dz * $urandom_range(1, 3);
        return IDX_W'(x + y * dx + z * dx * dy);
    endfunction

    initial begin
        int unsigned phase;
        sb = new();
        aresetn      <= 1'b0;
        cfg_wr_en    <= 1'b0;
        cfg_index    <= REG_DIM_X;
        cfg_data     <= '0;
        s_valid      <= 1'b0;
        s_node_index <= '0;
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // reset dims: index extremes and axis roll-overs
        send_node('0);
        send_node(1);
        send_node(AXIS_LIMIT - 1);
        send_node(AXIS_LIMIT);
        send_node(AXIS_LIMIT * AXIS_LIMIT - 1);
        send_node(AXIS_LIMIT * AXIS_LIMIT);
        send_node('1);
        send_node(30'h2AAA_AAAA);
        send_node(30'h1555_5555);
        drain_pipe();

        // small grid: corners, faces, and indices past the last node
        program_grid(11'd3, 11'd4, 11'd5);
        send_node(0);
        send_node(2);
        send_node(3);
        send_node(11);
        send_node(12);
        send_node(58);
        send_node(59);
        send_node(60);
        send_node(75);
        send_node('1);
        drain_pipe();

        // zero dims act as one; oversize dims saturate
        program_grid(11'd0, 11'd0, 11'd0);
        send_node(0);
        send_node(5);
        drain_pipe();
        program_grid(11'd2047, 11'd1025, 11'd1500);
        send_node(0);
        send_node(AXIS_LIMIT * AXIS_LIMIT + AXIS_LIMIT + 1);
        send_node('1);
        drain_pipe();

        for (phase = 0; phase < PHASES; phase++) begin
            case (phase)
                0:       program_grid(DIM_RESET, DIM_RESET, DIM_RESET);
                1:       program_grid(11'd1, 11'd1, 11'd1);
                2:       program_grid(11'd0, 11'd0, 11'd0);
                3:       program_grid(11'd2047, 11'd2047, 11'd2047);
                4:       program_grid(11'd3, 11'd4, 11'd5);
                5:       program_grid(11'd1, DIM_RESET, 11'd2);
                6:       program_grid(11'd1025, 11'd7, 11'd0);
                7:       program_grid(DIM_RESET, 11'd1, DIM_RESET);
                8:       program_grid(11'd1023, 11'd1023, 11'd1023);
                default: program_grid(CFG_W'($urandom_range(1, 48)),
                                      CFG_W'($urandom_range(1, 48)),
                                      CFG_W'($urandom_range(1, 48)));
            endcase
            case (phase % 4)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 77; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 77; end
                default: begin send_idle_pct = 10; recv_stall_pct = 10; end
            endcase
            // long sink hold-off while the source keeps pushing: fills the pipe
            if (phase == 4) hold_left = HOLD_CYCLES;
            repeat (ITEMS_PER_PHASE) send_node(pick_node());
            drain_pipe();
        end

        send_idle_pct  = 0;
        recv_stall_pct = 0;
        repeat (LATENCY + 20) @(posedge aclk);
        if (sb.fail_count == 0 && sb.pending_nodes.size() == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule

`default_nettype wire
